// File: rtl/core/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths and lane tables for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int InW    = 16;
  localparam int OutW   = 17;
  localparam int QuotW  = 16;
  localparam int DivW   = 34;
  localparam int DendW  = 53;
  localparam int NumW   = 52;
  localparam int MagW   = 51;
  localparam int Lanes  = 3;

  typedef logic [1:0] lane_idx_t;
  typedef lane_idx_t  lane_map_t [Lanes];

  // Cyclic neighbours for the cross product terms.
  localparam lane_map_t Next1 = '{2'd1, 2'd2, 2'd0};
  localparam lane_map_t Next2 = '{2'd2, 2'd0, 2'd1};

endpackage

// File: rtl/core/quaternion_vector_rotate_unit.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit
// Rotates a vector by a non-unit quaternion, exact, rounded to nearest.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid/in_stall with qw, qx, qy, qz, vx, vy, vz.
//   Result channel: out_valid/out_stall with rx, ry, rz, zero_quat.
//   A request is taken on an edge with valid high and stall low.
//   From request to result valid a request passes four arithmetic
//   stages (products, sums, wide products, numerator and dividend), sixteen
//   restoring divider stages giving one quotient bit each, one output stage.
//   One request per cycle unless stalled; the divider chain sets the depth.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits; data registers keep their contents.
//   An all-zero quaternion yields zero_quat set with zero components.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit
  import qvr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [InW-1:0]  qw,
  input  logic signed [InW-1:0]  qx,
  input  logic signed [InW-1:0]  qy,
  input  logic signed [InW-1:0]  qz,
  input  logic signed [InW-1:0]  vx,
  input  logic signed [InW-1:0]  vy,
  input  logic signed [InW-1:0]  vz,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [OutW-1:0] rx,
  output logic signed [OutW-1:0] ry,
  output logic signed [OutW-1:0] rz,
  output logic                   zero_quat
);

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic signed [InW-1:0] uin [Lanes];
  logic signed [InW-1:0] vin [Lanes];
  assign uin[0] = qx;
  assign uin[1] = qy;
  assign uin[2] = qz;
  assign vin[0] = vx;
  assign vin[1] = vy;
  assign vin[2] = vz;

  // stage 1: products
  logic                  v1;
  logic signed [31:0]    p_ww;
  logic signed [31:0]    p_uu [Lanes];
  logic signed [31:0]    p_uv [Lanes];
  logic signed [31:0]    p_ca [Lanes];
  logic signed [31:0]    p_cb [Lanes];
  logic signed [InW-1:0] w1;
  logic signed [InW-1:0] u1 [Lanes];
  logic signed [InW-1:0] vv1 [Lanes];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      p_ww <= qw * qw;
      w1   <= qw;
      for (int i = 0; i < Lanes; i++) begin
        p_uu[i] <= uin[i] * uin[i];
        p_uv[i] <= uin[i] * vin[i];
        p_ca[i] <= uin[Next1[i]] * vin[Next2[i]];
        p_cb[i] <= uin[Next2[i]] * vin[Next1[i]];
        u1[i]   <= uin[i];
        vv1[i]  <= vin[i];
      end
    end
  end

  // stage 2: sums
  logic signed [33:0] uu_c;
  logic signed [33:0] dot_c;
  assign uu_c  = 34'(p_uu[0]) + 34'(p_uu[1]) + 34'(p_uu[2]);
  assign dot_c = 34'(p_uv[0]) + 34'(p_uv[1]) + 34'(p_uv[2]);

  logic                  v2;
  logic [32:0]           n2;
  logic signed [33:0]    s2;
  logic signed [33:0]    d2;
  logic signed [32:0]    c2 [Lanes];
  logic signed [16:0]    w2;
  logic signed [InW-1:0] u2 [Lanes];
  logic signed [InW-1:0] vv2 [Lanes];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      n2 <= 33'(34'(p_ww) + uu_c);
      s2 <= 34'(p_ww) - uu_c;
      d2 <= dot_c <<< 1;
      w2 <= 17'(w1) <<< 1;
      for (int i = 0; i < Lanes; i++) begin
        c2[i]  <= 33'(p_ca[i]) - 33'(p_cb[i]);
        u2[i]  <= u1[i];
        vv2[i] <= vv1[i];
      end
    end
  end

  // stage 3: wide products
  logic               v3;
  logic [32:0]        n3;
  logic signed [49:0] m_s [Lanes];
  logic signed [49:0] m_d [Lanes];
  logic signed [49:0] m_c [Lanes];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      n3 <= n2;
      for (int i = 0; i < Lanes; i++) begin
        m_s[i] <= s2 * vv2[i];
        m_d[i] <= d2 * u2[i];
        m_c[i] <= w2 * c2[i];
      end
    end
  end

  // stage 4: numerator, sign, dividend
  logic signed [NumW-1:0] num_c  [Lanes];
  logic [MagW-1:0]        mag_c  [Lanes];
  logic [DendW-1:0]       dend_c [Lanes];
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      num_c[i]  = NumW'(m_s[i]) + NumW'(m_d[i]) + NumW'(m_c[i]);
      mag_c[i]  = num_c[i][NumW-1] ? MagW'(-num_c[i]) : MagW'(num_c[i]);
      dend_c[i] = {1'b0, mag_c[i], 1'b0} + DendW'(n3);
    end
  end

  // divider chain: one quotient bit per stage
  logic             dv   [QuotW+1];
  logic             dz   [QuotW+1];
  logic [DivW-1:0]  ddiv [QuotW+1];
  logic [DivW-1:0]  rem  [QuotW+1][Lanes];
  logic [QuotW-1:0] lowb [QuotW+1][Lanes];
  logic [QuotW-1:0] quo  [QuotW+1][Lanes];
  logic             dneg [QuotW+1][Lanes];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= v3;
    end
    if (adv) begin
      dz[0]   <= (n3 == '0);
      ddiv[0] <= {n3, 1'b0};
      for (int i = 0; i < Lanes; i++) begin
        rem[0][i]  <= dend_c[i][DivW+QuotW-1:QuotW];
        lowb[0][i] <= dend_c[i][QuotW-1:0];
        quo[0][i]  <= '0;
        dneg[0][i] <= num_c[i][NumW-1];
      end
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_div
    logic [DivW:0]   trial [Lanes];
    logic [DivW:0]   diff  [Lanes];
    always_comb begin
      for (int i = 0; i < Lanes; i++) begin
        trial[i] = {rem[k][i], lowb[k][i][QuotW-1]};
        diff[i]  = trial[i] - {1'b0, ddiv[k]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
      if (adv) begin
        dz[k+1]   <= dz[k];
        ddiv[k+1] <= ddiv[k];
        for (int i = 0; i < Lanes; i++) begin
          rem[k+1][i]  <= diff[i][DivW] ? trial[i][DivW-1:0] : diff[i][DivW-1:0];
          quo[k+1][i]  <= {quo[k][i][QuotW-2:0], !diff[i][DivW]};
          lowb[k+1][i] <= lowb[k][i] << 1;
          dneg[k+1][i] <= dneg[k][i];
        end
      end
    end
  end

  // output stage
  logic signed [OutW-1:0] res_c [Lanes];
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      if (dz[QuotW]) begin
        res_c[i] = '0;
      end else if (dneg[QuotW][i]) begin
        res_c[i] = -$signed({1'b0, quo[QuotW][i]});
      end else begin
        res_c[i] = $signed({1'b0, quo[QuotW][i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[QuotW];
    end
    if (adv) begin
      rx        <= res_c[0];
      ry        <= res_c[1];
      rz        <= res_c[2];
      zero_quat <= dz[QuotW];
    end
  end

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_quat |-> rx == '0 && ry == '0 && rz == '0)
    else $error("zero quaternion with non-zero result");

  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without a stalled result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rx) && $stable(zero_quat))
    else $error("stalled result changed");

endmodule
